// File: sv/dshot_telemetry_decoder_assert.svh
// assertion macros for the telemetry decoder
`ifndef DSHOT_TELEMETRY_DECODER_ASSERT_SVH
`define DSHOT_TELEMETRY_DECODER_ASSERT_SVH
`define DTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: sv/dtd_pkg.sv
package dtd_pkg;
	localparam int FRAME_LEN = 21;
	localparam logic [1:0] CMD_EDGE = 2'd0;
	localparam logic [1:0] CMD_DECODE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NONE = 3'd1;
	localparam logic [2:0] ST_BAD = 3'd2;
	localparam logic [2:0] ST_STOP = 3'd3;
	localparam logic [2:0] ST_ZERO = 3'd4;
	localparam logic [2:0] ST_EMPTY = 3'd5;
	localparam logic [25:0] ERPM_SCALE = 26'd60000000;
	localparam logic [11:0] STOP_PERIOD = 12'hfff;

	function automatic logic [4:0] gcr_nib(input logic [4:0] c);
		logic [4:0] r;
		case (c)
			5'd9: r = 5'd9;
			5'd10: r = 5'd10;
			5'd11: r = 5'd11;
			5'd13: r = 5'd13;
			5'd14: r = 5'd14;
			5'd15: r = 5'd15;
			5'd18: r = 5'd2;
			5'd19: r = 5'd3;
			5'd21: r = 5'd5;
			5'd22: r = 5'd6;
			5'd23: r = 5'd7;
			5'd25: r = 5'd0;
			5'd26: r = 5'd8;
			5'd27: r = 5'd1;
			5'd29: r = 5'd4;
			5'd30: r = 5'd12;
			default: r = 5'h10;
		endcase
		return r;
	endfunction
endpackage

// File: sv/dtd_div.sv
module dtd_div import dtd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic round_en,
	input logic [39:0] num,
	input logic [39:0] den,
	output logic busy,
	output logic done,
	output logic [39:0] quot
);
	logic [39:0] n_q, d_q, q_q;
	logic [40:0] r_q;
	logic [5:0] cnt_q;
	logic busy_q, done_q;
	logic rnd_q;
	logic [40:0] r_sh;
	logic [40:0] twice_r;
	logic round_up;

	assign r_sh = {r_q[39:0], n_q[39]};
	assign twice_r = {r_q[39:0], 1'b0};
	assign round_up = rnd_q && ((twice_r > {1'b0, d_q})
		|| (twice_r == {1'b0, d_q} && q_q[0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd40;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
			rnd_q <= round_en;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				quot <= q_q + {39'd0, round_up};
			end else begin
				n_q <= {n_q[38:0], 1'b0};
				if (r_sh >= {1'b0, d_q}) begin
					r_q <= r_sh - {1'b0, d_q};
					q_q <= {q_q[38:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[38:0], 1'b0};
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule

// File: sv/dshot_telemetry_decoder.sv
// an edge word passes S_EDGE, then S_WAIT while the divider runs, and gives no result;
// past the frame end it goes back to S_IDLE from S_EDGE without dividing. A decode or
// read passes S_DEC, then S_WAIT when the divider runs, then S_OUT, which registers the
// result word. ready is high only in S_IDLE with no result word waiting, so it is low
// while the shared 40-step restoring divider works (one quotient bit per cycle)
// reset: arst_n clears all line state, counters and bit_ticks (to 800) at once
module dshot_telemetry_decoder import dtd_pkg::*; #(
	parameter int NUM_LINES = 6,
	parameter int INTERVAL_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	// command[1:0], line[4:2], interval_ticks
	input logic [((5 + INTERVAL_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// line_out[2:0], result_kind[3], status[6:4], erpm[32:7], ok_count[64:33],
	// error_count[96:65], zeros
	output logic [103:0] m_tdata
);
	localparam int LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EDGE = 5'b00010,
		S_DEC = 5'b00100,
		S_WAIT = 5'b01000,
		S_OUT = 5'b10000
	} state_t;

	state_t state_q;
	logic [15:0] bit_ticks_q;
	logic [20:0] frame_q [NUM_LINES];
	logic [4:0] pos_q [NUM_LINES];
	logic [4:0] idx_q [NUM_LINES];
	logic got_q [NUM_LINES];
	logic [31:0] good_q [NUM_LINES];
	logic [31:0] bad_q [NUM_LINES];
	logic [39:0] sum_q [NUM_LINES];
	logic [7:0] smp_q [NUM_LINES];

	logic [1:0] cmd_q;
	logic [LW-1:0] line_q;
	logic [INTERVAL_WIDTH-1:0] ticks_q;
	logic [2:0] status_q;
	logic [25:0] erpm_q;
	logic ostart_q;
	logic div_start, div_busy, div_done, div_rnd;
	logic [39:0] div_num, div_den, div_quot;
	logic [103:0] out_q;
	logic out_v_q;

	logic [1:0] in_cmd;
	logic [2:0] in_line;
	logic [20:0] raw, gcr;
	logic [4:0] n0, n1, n2, n3;
	logic [15:0] data;
	logic [3:0] csum;
	logic [8:0] mant;
	logic [2:0] expo;
	logic [39:0] per;
	logic [5:0] endp;
	logic [20:0] ones;

	assign in_cmd = s_tdata[1:0];
	assign in_line = s_tdata[4:2];
	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	always_comb begin
		raw = frame_q[line_q];
		for (int i = 0; i < 21; i++) begin
			if (i < 21 - int'(pos_q[line_q])) raw[i] = 1'b1;
		end
		gcr = raw ^ {1'b0, raw[20:1]};
		n0 = gcr_nib(gcr[4:0]);
		n1 = gcr_nib(gcr[9:5]);
		n2 = gcr_nib(gcr[14:10]);
		n3 = gcr_nib(gcr[19:15]);
		data = {n3[3:0], n2[3:0], n1[3:0], n0[3:0]};
		csum = data[3:0] ^ data[7:4] ^ data[11:8] ^ data[15:12];
		mant = data[12:4];
		expo = data[15:13];
		per = {31'd0, mant} << expo;
		endp = 6'(pos_q[line_q]) + 6'(div_quot > 40'd21 ? 40'd21 : div_quot);
		if (endp > 6'd21) endp = 6'd21;
		ones = '0;
		for (int i = 0; i < 21; i++) begin
			if ((i >= 21 - int'(endp)) && (i < 21 - int'(pos_q[line_q]))) ones[i] = 1'b1;
		end
	end

	always_comb begin
		div_start = 1'b0;
		div_rnd = 1'b1;
		div_num = '0;
		div_den = 40'd1;
		if (state_q == S_EDGE) begin
			div_start = (idx_q[line_q] < 5'd21);
			div_num = 40'(ticks_q);
			div_den = (bit_ticks_q == 16'd0) ? 40'd1 : 40'(bit_ticks_q);
		end else if (state_q == S_DEC) begin
			div_start = (cmd_q == CMD_DECODE) ? (got_q[line_q] && n0[4] == 1'b0
				&& n1[4] == 1'b0 && n2[4] == 1'b0 && n3[4] == 1'b0
				&& csum == 4'hf && data[15:4] != STOP_PERIOD && mant != 9'd0)
				: (smp_q[line_q] != 8'd0);
			div_rnd = (cmd_q != CMD_DECODE);
			div_num = (cmd_q == CMD_DECODE) ? (40'(ERPM_SCALE) + (per >> 1)) : sum_q[line_q];
			div_den = (cmd_q == CMD_DECODE) ? per : 40'(smp_q[line_q]);
		end
	end

	dtd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .round_en(div_rnd), .num(div_num),
		.den(div_den), .busy(div_busy), .done(div_done), .quot(div_quot)
	);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= in_cmd;
			line_q <= LW'(in_line);
			ticks_q <= s_tdata[5 +: INTERVAL_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bit_ticks_q <= 16'd800;
			out_v_q <= 1'b0;
			ostart_q <= 1'b0;
			status_q <= ST_OK;
			erpm_q <= '0;
			out_q <= '0;
			for (int l = 0; l < NUM_LINES; l++) begin
				frame_q[l] <= '0; pos_q[l] <= '0; idx_q[l] <= '0; got_q[l] <= 1'b0;
				good_q[l] <= '0; bad_q[l] <= '0; sum_q[l] <= '0; smp_q[l] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) bit_ticks_q <= cfg_data;
			if (m_tvalid && m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready && 32'(in_line) < NUM_LINES) begin
						if (in_cmd == CMD_EDGE) state_q <= S_EDGE;
						else if (in_cmd == CMD_DECODE || in_cmd == CMD_READ) state_q <= S_DEC;
					end
				end
				S_EDGE: begin
					if (idx_q[line_q] >= 5'd21) state_q <= S_IDLE;
					else state_q <= S_WAIT;
				end
				S_DEC: begin
					erpm_q <= '0;
					ostart_q <= div_start;
					if (cmd_q == CMD_DECODE) begin
						if (!got_q[line_q]) status_q <= ST_NONE;
						else if (n0[4] || n1[4] || n2[4] || n3[4] || csum != 4'hf) begin
							status_q <= ST_BAD;
							bad_q[line_q] <= bad_q[line_q] + 32'd1;
						end else begin
							good_q[line_q] <= good_q[line_q] + 32'd1;
							if (data[15:4] == STOP_PERIOD) begin
								status_q <= ST_STOP;
								if (smp_q[line_q] != 8'd255)
									smp_q[line_q] <= smp_q[line_q] + 8'd1;
							end else if (mant == 9'd0) status_q <= ST_ZERO;
							else status_q <= ST_OK;
						end
						frame_q[line_q] <= '0; pos_q[line_q] <= '0;
						idx_q[line_q] <= '0; got_q[line_q] <= 1'b0;
					end else begin
						status_q <= (smp_q[line_q] != 8'd0) ? ST_OK : ST_EMPTY;
						sum_q[line_q] <= '0;
						smp_q[line_q] <= '0;
					end
					state_q <= div_start ? S_WAIT : S_OUT;
				end
				S_WAIT: begin
					if (div_done) begin
						if (cmd_q == CMD_EDGE) begin
							if (idx_q[line_q] == 5'd0 && ticks_q != '0) got_q[line_q] <= 1'b1;
							if (idx_q[line_q][0]) frame_q[line_q] <= frame_q[line_q] | ones;
							pos_q[line_q] <= endp[4:0];
							idx_q[line_q] <= idx_q[line_q] + 5'd1;
							state_q <= S_IDLE;
						end else begin
							erpm_q <= div_quot[25:0];
							if (cmd_q == CMD_DECODE && smp_q[line_q] != 8'd255) begin
								sum_q[line_q] <= sum_q[line_q] + 40'(div_quot[25:0]);
								smp_q[line_q] <= smp_q[line_q] + 8'd1;
							end
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					out_q <= {7'd0, bad_q[line_q], good_q[line_q], erpm_q, status_q,
						(cmd_q == CMD_READ), 3'(line_q)};
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "dshot_telemetry_decoder_assert.svh"
	`DTD_ASSERT_IMPL(a_busy_not_ready, clk, arst_n, div_busy, !s_tready)
	`DTD_ASSERT_IMPL(a_out_hold, clk, arst_n, out_v_q, state_q != S_OUT)
	`DTD_ASSERT_NEXT(a_dec_status, clk, arst_n, state_q == S_DEC && !ostart_q && div_start,
		state_q == S_WAIT)
endmodule

// File: tb/sv/tb_dshot_telemetry_decoder.sv
module tb_dshot_telemetry_decoder;
	import dtd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINES = 6;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	class telem_scoreboard;
		typedef struct {
			bit [2:0] ln;
			bit kind;
			bit [2:0] status;
			bit [25:0] erpm;
			bit [31:0] ok_cnt;
			bit [31:0] err_cnt;
		} telem_result_t;

		telem_result_t due_q[$];
		bit [15:0] bit_ticks = 16'd800;
		bit [20:0] frame[LINES];
		bit [4:0] pos[LINES];
		bit [4:0] edge_idx[LINES];
		bit heard[LINES];
		bit [31:0] good[LINES];
		bit [31:0] bad[LINES];
		bit [39:0] sum[LINES];
		bit [7:0] samples[LINES];
		int errors = 0;
		int results = 0;
		int status_seen[8];

		static function bit [4:0] nib_to_gcr(bit [3:0] n);
			bit [4:0] codes[16] = '{25, 27, 18, 19, 29, 21, 22, 23, 26, 9, 10, 11, 30, 13, 14, 15};
			return codes[n];
		endfunction

		static function longint unsigned round_div(longint unsigned n, longint unsigned d);
			longint unsigned q, r;
			q = n / d;
			r = n % d;
			if (r > d - r || (r == d - r && q[0]))
				q++;
			return q;
		endfunction

		function void clear_frame(int l);
			frame[l] = 0;
			pos[l] = 0;
			edge_idx[l] = 0;
			heard[l] = 0;
		endfunction

		function void add_sample(int l, bit [25:0] e);
			if (samples[l] != 8'd255) begin
				sum[l] = sum[l] + e;
				samples[l]++;
			end
		endfunction

		function bit [2:0] decode(int l, output bit [25:0] e);
			bit [20:0] raw;
			bit [19:0] g;
			bit [15:0] word;
			bit [11:0] period;
			bit found;
			int unsigned p;
			e = 0;
			if (!heard[l])
				return ST_NONE;
			raw = frame[l];
			if (pos[l] < FRAME_LEN)
				raw |= 21'((21'd1 << (FRAME_LEN - pos[l])) - 1);
			g = raw[19:0] ^ raw[20:1];
			for (int k = 0; k < 4; k++) begin
				found = 0;
				for (int n = 0; n < 16; n++)
					if (nib_to_gcr(4'(n)) == g[5*k +: 5]) begin
						word[4*k +: 4] = 4'(n);
						found = 1;
					end
				if (!found) begin
					bad[l]++;
					return ST_BAD;
				end
			end
			if ((word[3:0] ^ word[7:4] ^ word[11:8] ^ word[15:12]) != 4'hf) begin
				bad[l]++;
				return ST_BAD;
			end
			good[l]++;
			period = word[15:4];
			if (period == STOP_PERIOD) begin
				add_sample(l, '0);
				return ST_STOP;
			end
			if (period[8:0] == 0)
				return ST_ZERO;
			p = period[8:0] << period[11:9];
			e = 26'((ERPM_SCALE + p / 2) / p);
			add_sample(l, e);
			return ST_OK;
		endfunction

		function void note(bit [1:0] cmd, bit [2:0] ln, bit [15:0] ticks);
			telem_result_t x;
			int l;
			int unsigned nb, st, en;
			l = ln;
			if (ln >= LINES || cmd == CMD_UNUSED)
				return;
			if (cmd == CMD_EDGE) begin
				if (edge_idx[l] >= FRAME_LEN)
					return;
				if (edge_idx[l] == 0 && ticks != 0)
					heard[l] = 1;
				nb = 32'(round_div(ticks, bit_ticks == 0 ? 1 : bit_ticks));
				st = pos[l];
				en = st + nb > FRAME_LEN ? FRAME_LEN : st + nb;
				if (edge_idx[l][0])
					for (int b = st; b < en; b++)
						frame[l][FRAME_LEN - 1 - b] = 1;
				pos[l] = 5'(en);
				edge_idx[l]++;
				return;
			end
			x.ln = ln;
			x.erpm = 0;
			if (cmd == CMD_DECODE) begin
				x.kind = 0;
				x.status = decode(l, x.erpm);
				clear_frame(l);
			end else begin
				x.kind = 1;
				if (samples[l] != 0) begin
					x.erpm = 26'(round_div(sum[l], samples[l]));
					x.status = ST_OK;
				end else
					x.status = ST_EMPTY;
				sum[l] = 0;
				samples[l] = 0;
			end
			x.ok_cnt = good[l];
			x.err_cnt = bad[l];
			due_q.push_back(x);
		endfunction

		function void check(bit [103:0] d);
			telem_result_t x;
			bit miss;
			results++;
			if (due_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %h", d);
				return;
			end
			x = due_q.pop_front();
			status_seen[x.status]++;
			miss = d[2:0] != x.ln || d[3] != x.kind || d[6:4] != x.status ||
				d[32:7] != x.erpm || d[64:33] != x.ok_cnt || d[96:65] != x.err_cnt;
			if (miss) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp line %0d kind %0d st %0d erpm %0d ok %0d err %0d, got line %0d kind %0d st %0d erpm %0d ok %0d err %0d",
						x.ln, x.kind, x.status, x.erpm, x.ok_cnt, x.err_cnt,
						d[2:0], d[3], d[6:4], d[32:7], d[64:33], d[96:65]);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [15:0] cfg_data = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [23:0] s_tdata = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [103:0] m_tdata;

	telem_scoreboard sb = new();
	bit no_idle = 0;
	int words_sent = 0;
	int unsigned ivals[$];

	dshot_telemetry_decoder dut (.*);

	always #1 clk = ~clk;

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send(bit [1:0] cmd, bit [2:0] ln, bit [15:0] ticks);
		int n;
		n = no_idle ? 0 : $urandom_range(0, 15);
		if (n > 0) begin
			@(negedge clk) s_tvalid <= 0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tdata <= {3'b0, ticks, ln, cmd};
		do @(posedge clk); while (!s_tready);
		sb.note(cmd, ln, ticks);
		words_sent++;
	endtask

	task automatic settle();
		@(negedge clk) s_tvalid <= 0;
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_bit_ticks(bit [15:0] v);
		settle();
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.bit_ticks = v;
		@(negedge clk) cfg_valid <= 0;
	endtask

	// intervals for a frame carrying the 12-bit period, ones tail optional
	function automatic void build_frame(bit [11:0] period, bit [15:0] bt, bit keep_tail,
			bit jitter);
		bit [15:0] word;
		bit [19:0] g;
		bit [20:0] raw;
		int run, b, j, half;
		longint t;
		ivals.delete();
		word = {period, 4'hf ^ period[3:0] ^ period[7:4] ^ period[11:8]};
		for (int k = 0; k < 4; k++)
			g[5*k +: 5] = telem_scoreboard::nib_to_gcr(word[4*k +: 4]);
		raw[20] = 0;
		for (int i = 19; i >= 0; i--)
			raw[i] = raw[i + 1] ^ g[i];
		b = 20;
		while (b >= 0) begin
			run = 0;
			while (b - run >= 0 && raw[b - run] == raw[b])
				run++;
			if (!(raw[b] && b - run < 0 && !keep_tail)) begin
				half = bt < 2 ? 0 : (bt - 1) / 2;
				j = jitter ? int'($urandom_range(0, 2 * half)) - half : 0;
				t = longint'(run) * (bt == 0 ? 1 : bt) + j;
				ivals.push_back(32'(t > 65535 ? 65535 : t));
			end
			b -= run;
		end
	endfunction

	task automatic send_frame(bit [2:0] ln, bit [11:0] period, bit corrupt);
		build_frame(period, sb.bit_ticks, 1'($urandom_range(0, 1)), 1);
		if (corrupt && ivals.size() > 0)
			ivals[$urandom_range(0, ivals.size() - 1)] = $urandom_range(0, 65535);
		foreach (ivals[i])
			send(CMD_EDGE, ln, 16'(ivals[i]));
		send(CMD_DECODE, ln, 16'($urandom));
	endtask

	function automatic bit [15:0] noise_ticks();
		int unsigned bt, k;
		bt = sb.bit_ticks == 0 ? 1 : sb.bit_ticks;
		k = $urandom_range(0, 6);
		case ($urandom_range(0, 3))
			0: return 16'(k * bt + bt / 2 > 65535 ? 65535 : k * bt + bt / 2);
			1: return $urandom_range(0, 1) ? 16'hffff : 16'h0;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic bit [11:0] pick_period();
		case ($urandom_range(0, 9))
			0: return STOP_PERIOD;
			1: return {3'($urandom_range(0, 7)), 9'd0};
			2: return 12'd1;
			default: return 12'($urandom_range(1, 4094));
		endcase
	endfunction

	task automatic random_phase(int count);
		int target;
		bit [2:0] ln;
		bit can_frame;
		target = words_sent + count;
		can_frame = sb.bit_ticks <= 3000;
		while (words_sent < target) begin
			ln = 3'($urandom_range(0, LINES - 1));
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
					if (can_frame)
						send_frame(ln, pick_period(), 0);
					else
						send(CMD_EDGE, ln, noise_ticks());
				11, 12: send(CMD_READ, ln, 16'($urandom));
				13, 14:
					repeat ($urandom_range(1, 5)) send(CMD_EDGE, ln, noise_ticks());
				15: send(CMD_DECODE, ln, 16'($urandom));
				16: send(CMD_UNUSED, ln, 16'($urandom));
				17: send(2'($urandom_range(0, 3)), 3'($urandom_range(LINES, 7)),
					16'($urandom));
				default:
					if (can_frame)
						send_frame(ln, pick_period(), 1);
					else
						send(CMD_DECODE, ln, 16'($urandom));
			endcase
		end
	endtask

	initial begin : receiver
		int n;
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 15);
			if (n > 0) begin
				@(negedge clk) m_tready <= 0;
				repeat (n) @(negedge clk);
			end else
				@(negedge clk);
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			sb.check(m_tdata);
		end
	end

	initial begin : stimulus
		bit [15:0] settings[6];
		settings = '{16'd800, 16'd1, 16'd0, 16'd65535, 16'($urandom_range(100, 3000)),
			16'd2};
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed
		send(CMD_READ, 0, 0);
		send(CMD_DECODE, 0, 0);
		send(CMD_EDGE, 1, 0);
		send(CMD_EDGE, 1, 16'hffff);
		send(CMD_DECODE, 1, 16'hffff);
		send_frame(2, 12'h2a5, 0);
		send_frame(2, STOP_PERIOD, 0);
		send_frame(2, 12'he00, 0);
		send_frame(3, 12'd1, 0);
		send_frame(3, 12'hffe, 0);
		send(CMD_EDGE, 4, 16'd800);
		send(CMD_EDGE, 4, 16'd2400);
		send(CMD_DECODE, 4, 0);
		repeat (23) send(CMD_EDGE, 5, 16'd400);
		send(CMD_DECODE, 5, 0);
		send(CMD_UNUSED, 0, 16'hffff);
		send(CMD_DECODE, 7, 16'hffff);
		send(CMD_READ, 6, 0);
		send(CMD_READ, 2, 0);
		send(CMD_READ, 3, 0);

		// back-to-back frames on one line, then one average read
		settle();
		no_idle = 1;
		repeat (40) send_frame(0, 12'h3c7, 0);
		send(CMD_READ, 0, 0);
		no_idle = 0;

		foreach (settings[i]) begin
			write_bit_ticks(settings[i]);
			random_phase(70);
			no_idle = 1;
			random_phase(30);
			no_idle = 0;
			random_phase(40);
		end
		settle();
		$display("sent %0d words, checked %0d results over six bit_ticks settings",
			words_sent, sb.results);
		$display("statuses ok %0d none %0d bad %0d stop %0d zero %0d empty %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.status_seen[4], sb.status_seen[5]);
		if (sb.errors == 0 && sb.due_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
